@@ rtl/core/ecmp_pkg.sv @@
// ----------------------------------------------------------------------------
// ecmp_pkg
// Shared constants, types and helpers for the ecmp next-hop select block.
// ----------------------------------------------------------------------------
package ecmp_pkg;

  localparam int NUM_NODES_DEF      = 256;
  localparam int MAX_CANDIDATES_DEF = 8;

  localparam int HASH_W   = 32;
  localparam int CNT_W    = 4;
  localparam int HOP_W    = 8;
  localparam int DEST_W   = 8;
  localparam int SLOT_W   = 3;
  localparam int NKEY     = 6;
  localparam int NBLK     = 5;
  localparam int MOD_STEP = 8;
  localparam int MOD_STG  = HASH_W / MOD_STEP;

  localparam logic [31:0] PERTURB   = 32'd1333527522;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [31:0] KEY_LEN   = 32'd21;
  localparam logic [31:0] SEED_RST  = 32'h8BADF00D;

  localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2   = 32'h1b873593;
  localparam logic [31:0] MM_ADD  = 32'he6546b64;
  localparam logic [31:0] MM_FIN1 = 32'h85ebca6b;
  localparam logic [31:0] MM_FIN2 = 32'hc2b2ae35;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_COUNT  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOCAND = 2'd1;
  localparam logic [1:0] ST_PORT   = 2'd2;

  localparam logic REG_NODE_ID   = 1'b0;
  localparam logic REG_HASH_SEED = 1'b1;

  typedef logic [NKEY-1:0][31:0] key_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DEST_W-1:0] dest;
    logic              dest_ok;
    logic [SLOT_W-1:0] slot;
    logic [HOP_W-1:0]  hop;
    logic              port_err;
    logic [CNT_W-1:0]  cnt;
  } side_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

@@ rtl/core/ecmp_ram.sv @@
// ----------------------------------------------------------------------------
// ecmp_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ecmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ecmp_hash.sv @@
// ----------------------------------------------------------------------------
// ecmp_hash
// Pipelined murmur3 x86 32-bit over the six key words, one block per stage.
// ----------------------------------------------------------------------------
module ecmp_hash import ecmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  side_t       side_i,
  input  key_t        key_i,
  input  logic [31:0] seed_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic [31:0] hash_o
);

  // key mixing
  logic  v1_q, v2_q;
  side_t sd1_q, sd2_q;
  key_t  kx_q, ky_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd1_q <= side_i;
      sd2_q <= sd1_q;
      for (int i = 0; i < NKEY; i++) begin
        kx_q[i] <= key_i[i] * MM_C1;
        ky_q[i] <= rotl32(kx_q[i], 15) * MM_C2;
      end
    end
  end

  // body blocks
  logic        vb_q  [NBLK];
  side_t       sdb_q [NBLK];
  key_t        kyb_q [NBLK];
  logic [31:0] hb_q  [NBLK];

  for (genvar b = 0; b < NBLK; b++) begin : g_blk
    logic        v_in;
    side_t       sd_in;
    key_t        ky_in;
    logic [31:0] h_in, h_x;

    if (b == 0) begin : g_first
      assign v_in  = v2_q;
      assign sd_in = sd2_q;
      assign ky_in = ky_q;
      assign h_in  = seed_i;
    end else begin : g_next
      assign v_in  = vb_q[b-1];
      assign sd_in = sdb_q[b-1];
      assign ky_in = kyb_q[b-1];
      assign h_in  = hb_q[b-1];
    end

    assign h_x = rotl32(h_in ^ ky_in[b], 13);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vb_q[b] <= 1'b0;
      end else if (en_i) begin
        vb_q[b] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sdb_q[b] <= sd_in;
        kyb_q[b] <= ky_in;
        hb_q[b]  <= (h_x << 2) + h_x + MM_ADD;
      end
    end
  end

  // tail and finalization
  logic        vf1_q, vf2_q, vf3_q;
  side_t       sdf1_q, sdf2_q, sdf3_q;
  logic [31:0] hf1_q, hf2_q, hf3_q;
  logic [31:0] t_tail, t_mix13;

  assign t_tail  = hb_q[NBLK-1] ^ kyb_q[NBLK-1][NKEY-1] ^ KEY_LEN;
  assign t_mix13 = hf2_q ^ (hf2_q >> 13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
      vf3_q <= 1'b0;
    end else if (en_i) begin
      vf1_q <= vb_q[NBLK-1];
      vf2_q <= vf1_q;
      vf3_q <= vf2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sdf1_q <= sdb_q[NBLK-1];
      sdf2_q <= sdf1_q;
      sdf3_q <= sdf2_q;
      hf1_q  <= t_tail ^ (t_tail >> 16);
      hf2_q  <= hf1_q * MM_FIN1;
      hf3_q  <= t_mix13 * MM_FIN2;
    end
  end

  assign valid_o = vf3_q;
  assign side_o  = sdf3_q;
  assign hash_o  = hf3_q ^ (hf3_q >> 16);

endmodule

@@ rtl/core/ecmp_mod.sv @@
// ----------------------------------------------------------------------------
// ecmp_mod
// Pipelined restoring remainder of the hash by the candidate count.
// ----------------------------------------------------------------------------
module ecmp_mod import ecmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  side_t            side_i,
  input  logic [31:0]      hash_i,
  output logic             valid_o,
  output side_t            side_o,
  output logic [31:0]      hash_o,
  output logic [CNT_W-1:0] rem_o
);

  logic             v_q  [MOD_STG];
  side_t            sd_q [MOD_STG];
  logic [31:0]      dv_q [MOD_STG];
  logic [31:0]      hs_q [MOD_STG];
  logic [CNT_W-1:0] r_q  [MOD_STG];

  for (genvar g = 0; g < MOD_STG; g++) begin : g_stg
    logic             v_in;
    side_t            sd_in;
    logic [31:0]      dv_in, hs_in, dv_out;
    logic [CNT_W-1:0] r_in, r_out;

    if (g == 0) begin : g_first
      assign v_in  = valid_i;
      assign sd_in = side_i;
      assign dv_in = hash_i;
      assign hs_in = hash_i;
      assign r_in  = '0;
    end else begin : g_next
      assign v_in  = v_q[g-1];
      assign sd_in = sd_q[g-1];
      assign dv_in = dv_q[g-1];
      assign hs_in = hs_q[g-1];
      assign r_in  = r_q[g-1];
    end

    always_comb begin
      logic [CNT_W:0] t;
      r_out  = r_in;
      dv_out = dv_in;
      for (int j = 0; j < MOD_STEP; j++) begin
        t      = {r_out, dv_out[31]};
        dv_out = {dv_out[30:0], 1'b0};
        if (t >= {1'b0, sd_in.cnt}) begin
          t = t - {1'b0, sd_in.cnt};
        end
        r_out = t[CNT_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[g] <= sd_in;
        dv_q[g] <= dv_out;
        hs_q[g] <= hs_in;
        r_q[g]  <= r_out;
      end
    end
  end

  assign valid_o = v_q[MOD_STG-1];
  assign side_o  = sd_q[MOD_STG-1];
  assign hash_o  = hs_q[MOD_STG-1];
  assign rem_o   = r_q[MOD_STG-1];

endmodule

@@ rtl/core/ecmp_five_tuple_next_hop_select.sv @@
// ----------------------------------------------------------------------------
// ecmp_five_tuple_next_hop_select
// Equal-cost multipath next-hop select by murmur3 hash of the five-tuple.
// ----------------------------------------------------------------------------
// The input channel (in_valid_i/in_ready_o) carries one transaction per packet
// or table update; the output channel (out_valid_o/out_ready_i) returns one
// result transaction for each, in order. Mode 0 looks up a next hop, mode 1
// writes a candidate slot, mode 2 sets a destination's candidate count.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) sets node id and
// hash seed.
// Throughput is one transaction per cycle while not stalled. A result passes
// one key register, ten hash stages, four remainder stages and the candidate
// table read, which shares the last register with the output.
// The count memory is read at acceptance, the candidate table at the end of the
// pipe, so writes and lookups take effect in transaction order.
// After reset the block clears the count memory, one entry per cycle, with
// in_ready_o low until all NUM_NODES entries are clear.
// When the receiver stalls, the whole pipe holds and in_ready_o drops.
// ----------------------------------------------------------------------------
module ecmp_five_tuple_next_hop_select import ecmp_pkg::*; #(
  parameter int NUM_NODES      = NUM_NODES_DEF,
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [DEST_W-1:0]   dest_node_i,
  input  logic [31:0]         source_ip_i,
  input  logic [31:0]         destination_ip_i,
  input  logic [7:0]          protocol_i,
  input  logic [12:0]         fragment_offset_i,
  input  logic [15:0]         source_port_i,
  input  logic [15:0]         destination_port_i,
  input  logic                no_next_header_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [HOP_W-1:0]    hop_value_i,
  input  logic [CNT_W-1:0]    count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [HOP_W-1:0]    next_hop_o,
  output logic [1:0]          status_o,
  output logic [HASH_W-1:0]   hash_value_o
);

  localparam int NAW = $clog2(NUM_NODES);
  localparam int TAW = $clog2(NUM_NODES * MAX_CANDIDATES);

  // configuration
  logic [15:0] node_id_q;
  logic [31:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= '0;
      seed_q    <= SEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NODE_ID:   node_id_q <= cfg_wdata_i[15:0];
        REG_HASH_SEED: seed_q    <= cfg_wdata_i;
        default:       seed_q    <= seed_q;
      endcase
    end
  end

  // flow control and count clearing
  logic           en, acc;
  logic           clr_busy_q;
  logic [NAW-1:0] clr_q;
  logic           t_valid_q;

  assign en         = !t_valid_q || out_ready_i;
  assign in_ready_o = en && !clr_busy_q;
  assign acc        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == NAW'(NUM_NODES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // key assembly and count access
  logic              ports_used, dest_ok;
  logic [15:0]       sp, dp;
  logic [CNT_W-1:0]  cnt_sat, cnt_rdata;
  logic [NAW+7:0]    dest_ext;
  logic [NAW-1:0]    cnt_addr;
  logic              cnt_we;
  key_t              key_d;
  side_t             side_d;

  assign ports_used = !no_next_header_i && (fragment_offset_i == '0) &&
                      ((protocol_i == PROTO_TCP) || (protocol_i == PROTO_UDP));
  assign sp         = ports_used ? source_port_i : '0;
  assign dp         = ports_used ? destination_port_i : '0;
  assign dest_ok    = 32'(dest_node_i) < NUM_NODES;
  assign cnt_sat    = (32'(count_i) > MAX_CANDIDATES) ? CNT_W'(MAX_CANDIDATES) : count_i;
  assign dest_ext   = (NAW + 8)'(dest_node_i);
  assign cnt_addr   = clr_busy_q ? clr_q : dest_ext[NAW-1:0];
  assign cnt_we     = clr_busy_q || (acc && (mode_i == MODE_COUNT) && dest_ok);

  assign key_d[0] = {source_ip_i[7:0], source_ip_i[15:8],
                     source_ip_i[23:16], source_ip_i[31:24]};
  assign key_d[1] = {destination_ip_i[7:0], destination_ip_i[15:8],
                     destination_ip_i[23:16], destination_ip_i[31:24]};
  assign key_d[2] = {dp[15:8], sp[7:0], sp[15:8], protocol_i};
  assign key_d[3] = {node_id_q[15:8], 16'h0000, dp[7:0]};
  assign key_d[4] = {PERTURB[15:8], PERTURB[23:16], PERTURB[31:24], node_id_q[7:0]};
  assign key_d[5] = {24'h000000, PERTURB[7:0]};

  assign side_d.mode     = mode_i;
  assign side_d.dest     = dest_node_i;
  assign side_d.dest_ok  = dest_ok;
  assign side_d.slot     = slot_i;
  assign side_d.hop      = hop_value_i;
  assign side_d.port_err = ports_used && ((sp == '0) || (dp == '0));
  assign side_d.cnt      = '0;

  ecmp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_NODES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .re_i    (en),
    .addr_i  (cnt_addr),
    .wdata_i (clr_busy_q ? '0 : cnt_sat),
    .rdata_o (cnt_rdata)
  );

  logic  s1_valid_q;
  key_t  s1_key_q;
  side_t s1_side_q, s1_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_key_q  <= key_d;
      s1_side_q <= side_d;
    end
  end

  always_comb begin
    s1_side     = s1_side_q;
    s1_side.cnt = s1_side_q.dest_ok ? cnt_rdata : '0;
  end

  // hash and remainder
  logic        h_valid, m_valid;
  side_t       h_side, m_side;
  logic [31:0] h_hash, m_hash;
  logic [CNT_W-1:0] m_rem;

  ecmp_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_valid_q),
    .side_i  (s1_side),
    .key_i   (s1_key_q),
    .seed_i  (seed_q),
    .valid_o (h_valid),
    .side_o  (h_side),
    .hash_o  (h_hash)
  );

  ecmp_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_valid),
    .side_i  (h_side),
    .hash_i  (h_hash),
    .valid_o (m_valid),
    .side_o  (m_side),
    .hash_o  (m_hash),
    .rem_o   (m_rem)
  );

  // candidate table and output register
  logic              is_lookup, is_write, slot_ok, tbl_we, hit_d;
  logic [SLOT_W-1:0] sel;
  logic [TAW-1:0]    tbl_addr;
  logic [HOP_W-1:0]  tbl_rdata;
  logic [1:0]        status_d;

  assign is_lookup = m_side.mode == MODE_LOOKUP;
  assign is_write  = m_side.mode == MODE_WRITE;
  assign slot_ok   = 32'(m_side.slot) < MAX_CANDIDATES;
  assign sel       = is_write ? m_side.slot : SLOT_W'(m_rem);
  assign tbl_addr  = TAW'(32'(m_side.dest) * MAX_CANDIDATES + 32'(sel));
  assign tbl_we    = en && m_valid && is_write && m_side.dest_ok && slot_ok;
  assign hit_d     = is_lookup && !m_side.port_err && (m_side.cnt != '0);

  always_comb begin
    status_d = ST_OK;
    if (is_lookup) begin
      priority if (m_side.port_err) begin
        status_d = ST_PORT;
      end else if (m_side.cnt == '0) begin
        status_d = ST_NOCAND;
      end else begin
        status_d = ST_OK;
      end
    end
  end

  ecmp_ram #(
    .WIDTH (HOP_W),
    .DEPTH (NUM_NODES * MAX_CANDIDATES)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .re_i    (en),
    .addr_i  (tbl_addr),
    .wdata_i (m_side.hop),
    .rdata_o (tbl_rdata)
  );

  logic        t_hit_q;
  logic [1:0]  t_status_q;
  logic [31:0] t_hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
    end else if (en) begin
      t_valid_q <= m_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_hit_q    <= hit_d;
      t_status_q <= status_d;
      t_hash_q   <= is_lookup ? m_hash : '0;
    end
  end

  assign out_valid_o  = t_valid_q;
  assign next_hop_o   = t_hit_q ? tbl_rdata : '0;
  assign status_o     = t_status_q;
  assign hash_value_o = t_hash_q;

endmodule

@@ rtl/core/ecmp_chk.sv @@
// ----------------------------------------------------------------------------
// ecmp_chk
// Port-level checks for the ecmp next-hop select block.
// ----------------------------------------------------------------------------
module ecmp_chk import ecmp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [HOP_W-1:0]  next_hop_o,
  input logic [1:0]        status_o,
  input logic [HASH_W-1:0] hash_value_o
);

  // error results carry no next hop
  a_err_no_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> next_hop_o == '0)
    else $error("next hop on error status");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_hop_o) &&
      $stable(status_o) && $stable(hash_value_o))
    else $error("stalled result changed");

  // count clearing blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input accepted during count clearing");

endmodule

bind ecmp_five_tuple_next_hop_select ecmp_chk u_chk (.*);

@@ dv/ecmp_five_tuple_next_hop_select_tb.sv @@
// ----------------------------------------------------------------------------
// ecmp_five_tuple_next_hop_select_tb
// Self-checking bench: directed table then random packet lookups and table
// updates, predicted in order and compared field by field at the output.
// ----------------------------------------------------------------------------
module ecmp_five_tuple_next_hop_select_tb;
  import ecmp_pkg::*;

  localparam int NODES      = NUM_NODES_DEF;
  localparam int CANDS      = MAX_CANDIDATES_DEF;
  localparam int LAT        = 20;
  localparam int LIMIT      = 400000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  dest;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [7:0]  proto;
    logic [12:0] frag;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        nonext;
    logic [2:0]  slot;
    logic [7:0]  hop;
    logic [3:0]  cnt;
  } pkt_t;

  typedef struct packed {
    logic [7:0]  hop;
    logic [1:0]  status;
    logic [31:0] hash;
  } hop_res_t;

  typedef struct {
    pkt_t     p;
    logic     known;
    hop_res_t r;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  pkt_t cur;
  logic [7:0] next_hop_o;
  logic [1:0] status_o;
  logic [31:0] hash_value_o;

  ecmp_five_tuple_next_hop_select dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .mode_i(cur.mode), .dest_node_i(cur.dest), .source_ip_i(cur.sip),
    .destination_ip_i(cur.dip), .protocol_i(cur.proto),
    .fragment_offset_i(cur.frag), .source_port_i(cur.sport),
    .destination_port_i(cur.dport), .no_next_header_i(cur.nonext),
    .slot_i(cur.slot), .hop_value_i(cur.hop), .count_i(cur.cnt),
    .out_valid_o, .out_ready_i,
    .next_hop_o, .status_o, .hash_value_o
  );

  // predictor state
  logic [7:0]  hop_tbl [NODES*CANDS];
  bit          hop_written [NODES*CANDS];
  logic [3:0]  cand_cnt [NODES];
  logic [15:0] my_node;
  logic [31:0] my_seed;

  hop_res_t pending_hops[$];
  int errors, sent, got, cycles, lookups, hold_cycles;
  bit quiet, long_hold;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ecmp_five_tuple_next_hop_select test failed");
      $finish;
    end
  end

  function automatic logic [31:0] rl(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] murmur_key(logic [7:0] kb [21], logic [31:0] seed);
    logic [31:0] h, k;
    h = seed;
    for (int b = 0; b < 5; b++) begin
      k = {kb[4*b+3], kb[4*b+2], kb[4*b+1], kb[4*b]};
      k = k * 32'hcc9e2d51;
      k = rl(k, 15);
      k = k * 32'h1b873593;
      h = h ^ k;
      h = rl(h, 13);
      h = h * 5 + 32'he6546b64;
    end
    k = {24'd0, kb[20]};
    k = k * 32'hcc9e2d51;
    k = rl(k, 15);
    k = k * 32'h1b873593;
    h = h ^ k ^ 32'd21;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic bit uses_ports(pkt_t p);
    return !p.nonext && p.frag == 0 && (p.proto == PROTO_TCP || p.proto == PROTO_UDP);
  endfunction

  function automatic hop_res_t predict_hop(pkt_t p);
    hop_res_t r;
    logic [7:0] kb [21];
    logic [15:0] sp, dp;
    logic [31:0] nid, n;
    bit pu;
    r = '0;
    if (p.mode == MODE_WRITE) begin
      hop_tbl[p.dest*CANDS + p.slot] = p.hop;
      hop_written[p.dest*CANDS + p.slot] = 1;
    end else if (p.mode == MODE_COUNT) begin
      cand_cnt[p.dest] = (p.cnt > CANDS) ? 4'(CANDS) : p.cnt;
    end else if (p.mode == MODE_LOOKUP) begin
      pu = uses_ports(p);
      sp = pu ? p.sport : 16'd0;
      dp = pu ? p.dport : 16'd0;
      nid = {16'd0, my_node};
      for (int i = 0; i < 4; i++) begin
        kb[i]      = p.sip[31-8*i -: 8];
        kb[4+i]    = p.dip[31-8*i -: 8];
        kb[13+i]   = nid[31-8*i -: 8];
        kb[17+i]   = PERTURB[31-8*i -: 8];
      end
      kb[8] = p.proto;
      kb[9] = sp[15:8]; kb[10] = sp[7:0]; kb[11] = dp[15:8]; kb[12] = dp[7:0];
      r.hash = murmur_key(kb, my_seed);
      n = 32'(cand_cnt[p.dest]);
      if (pu && (sp == 0 || dp == 0)) r.status = ST_PORT;
      else if (n == 0) r.status = ST_NOCAND;
      else r.hop = hop_tbl[p.dest*CANDS + r.hash % n];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, seen, want, got);
    errors++;
  endtask

  // output side: random stall bursts and one long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 0;
      hold_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_hops.size() == 0) begin
          $display("unexpected result transaction");
          errors++;
        end else begin
          hop_res_t w;
          w = pending_hops.pop_front();
          if (next_hop_o !== w.hop)
            report_mismatch("next_hop", 32'(next_hop_o), 32'(w.hop));
          if (status_o !== w.status)
            report_mismatch("status", 32'(status_o), 32'(w.status));
          if (hash_value_o !== w.hash) report_mismatch("hash_value", hash_value_o, w.hash);
        end
        got <= got + 1;
      end
      if (long_hold) begin
        out_ready_i <= 0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold_cycles <= $urandom_range(0, 15);
        out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  task automatic send(pkt_t p);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    cur <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pending_hops.push_back(predict_hop(p));
    if (p.mode == MODE_LOOKUP) lookups++;
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending_hops.size() != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic set_reg(logic idx, logic [31:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    if (idx == REG_NODE_ID) my_node = v[15:0];
    else my_seed = v;
  endtask

  function automatic pkt_t rand_pkt(int mode_w);
    pkt_t p;
    p = '0;
    p.dest = 8'($urandom_range(0, 15));
    p.sip = $urandom; p.dip = $urandom;
    p.sport = 16'($urandom); p.dport = 16'($urandom);
    case ($urandom_range(0, 3))
      0: p.proto = PROTO_TCP;
      1: p.proto = PROTO_UDP;
      2: p.proto = 8'($urandom);
      default: p.proto = PROTO_TCP;
    endcase
    p.frag = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'd0;
    p.nonext = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 19) == 0) p.sport = 0;
    if ($urandom_range(0, 19) == 0) p.dport = 0;
    p.slot = 3'($urandom); p.hop = 8'($urandom); p.cnt = 4'($urandom);
    if (mode_w < 70) p.mode = MODE_LOOKUP;
    else if (mode_w < 82) p.mode = MODE_WRITE;
    else if (mode_w < 97) p.mode = MODE_COUNT;
    else p.mode = MODE_UNUSED;
    // never let a lookup reach a slot that was never written
    if (p.mode == MODE_COUNT)
      for (int s = 0; s < CANDS; s++)
        if (!hop_written[p.dest*CANDS + s] && s < p.cnt) p.cnt = 4'(s);
    return p;
  endfunction

  function automatic row_t mk(pkt_t p, logic known, hop_res_t r);
    row_t t;
    t.p = p; t.known = known; t.r = r;
    return t;
  endfunction

  row_t rows[$];

  initial begin
    pkt_t p, b;
    hop_res_t want;
    int n;
    logic [31:0] seeds [4];
    rst_ni = 0; in_valid_i = 0; cfg_we_i = 0; cfg_idx_i = 0; cfg_wdata_i = 0;
    cur = '0; errors = 0; sent = 0; got = 0; cycles = 0; lookups = 0;
    quiet = 0; long_hold = 0;
    foreach (cand_cnt[i]) cand_cnt[i] = 0;
    foreach (hop_written[i]) begin
      hop_written[i] = 0;
      hop_tbl[i] = 0;
    end
    my_node = 0; my_seed = SEED_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    // directed rows
    b = '0; b.sip = 32'hC0A80001; b.dip = 32'h0A000001; b.proto = PROTO_TCP;
    b.sport = 16'd1234; b.dport = 16'd80;
    p = b; rows.push_back(mk(p, 0, '0));                          // no candidates yet
    p = b; p.sport = 0; rows.push_back(mk(p, 0, '0));             // zero port wins
    p = b; p.proto = PROTO_UDP; p.dport = 0; rows.push_back(mk(p, 0, '0));
    p = b; p.dest = 8'hFF; rows.push_back(mk(p, 0, '0));
    for (int s = 0; s < CANDS; s++) begin
      p = '0; p.mode = MODE_WRITE; p.slot = 3'(s); p.hop = 8'(32'hA0 + s);
      rows.push_back(mk(p, 1, '0));
      p.dest = 8'hFF; p.hop = 8'(32'hFF - s); rows.push_back(mk(p, 1, '0));
    end
    p = '0; p.mode = MODE_COUNT; p.cnt = 4'hF; rows.push_back(mk(p, 1, '0)); // saturates
    p = '0; p.mode = MODE_COUNT; p.dest = 8'hFF; p.cnt = 4'd1; rows.push_back(mk(p, 1, '0));
    p = b; rows.push_back(mk(p, 0, '0));
    p = b; p.dest = 8'hFF; rows.push_back(mk(p, 0, '0));
    p = b; p.nonext = 1; p.sport = 0; rows.push_back(mk(p, 0, '0));
    p = b; p.frag = 13'h1FFF; p.dport = 0; rows.push_back(mk(p, 0, '0));
    p = '1; p.mode = MODE_UNUSED; rows.push_back(mk(p, 1, '0));
    p = '1; p.mode = MODE_LOOKUP; p.proto = PROTO_UDP; p.frag = 0; p.nonext = 0;
    rows.push_back(mk(p, 0, '0));

    foreach (rows[i]) begin
      if (rows[i].known) begin
        want = predict_hop(rows[i].p);
        if (want !== rows[i].r) begin
          $display("table row %0d disagrees with predictor", i);
          errors++;
        end
      end
      send(rows[i].p);
    end
    drain();

    seeds = '{32'h0, 32'hFFFFFFFF, SEED_RST, $urandom};
    for (int ph = 0; ph < 4; ph++) begin
      set_reg(REG_NODE_ID, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF : $urandom);
      set_reg(REG_HASH_SEED, seeds[ph]);
      cfg_we_i <= 0;
      n = (ph == 3) ? 250 : 190;
      if (ph == 1) begin
        fork
          begin
            long_hold = 1;
            repeat (60) @(posedge clk_i);
            long_hold = 0;
          end
        join_none
      end
      if (ph == 3) quiet = 1;
      for (int i = 0; i < n; i++) send(rand_pkt($urandom_range(0, 99)));
      drain();
    end

    $display("sent %0d transactions (%0d lookups), checked %0d results over 4 settings",
             sent, lookups, got);
    if (errors == 0 && pending_hops.size() == 0)
      $display("ecmp_five_tuple_next_hop_select test passed");
    else
      $display("ecmp_five_tuple_next_hop_select test failed");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/ecmp_pkg.sv
rtl/core/ecmp_ram.sv
rtl/core/ecmp_hash.sv
rtl/core/ecmp_mod.sv
rtl/core/ecmp_five_tuple_next_hop_select.sv
rtl/core/ecmp_chk.sv
dv/ecmp_five_tuple_next_hop_select_tb.sv
